FILE: hdl/ntc_thermistor_to_fahrenheit_defines.svh
// assertion macros for the checker file
`ifndef NTC_THERMISTOR_TO_FAHRENHEIT_DEFINES_SVH
`define NTC_THERMISTOR_TO_FAHRENHEIT_DEFINES_SVH

// clocked assertion, disabled while reset is held
`define NTCF_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define NTCF_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/ntcf_pkg.sv
// shared types, codes and constants of the thermistor converter
`default_nettype none

package ntcf_pkg;

    localparam int ADC_BITS_DEF   = 12;
    localparam int COEF_FRAC_DEF  = 48;
    localparam int SER_W          = 20;
    localparam int COEF_W         = 48;
    localparam int CFG_IDX_W      = 3;
    localparam int TEMP_W         = 10;
    localparam int LOG_FRAC       = 26;
    localparam int LN_NORM        = 30;
    localparam int L_W            = 31;
    localparam int L2_W           = 36;
    localparam int L3_W           = 40;
    localparam int INV_W          = 64;
    localparam int LAT_FIXED      = 72;

    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERIES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_C = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_SAT     = 2'd2;

    localparam logic [SER_W-1:0]  SERIES_RST = 20'd102000;
    localparam logic [COEF_W-1:0] COEF_A_RST = 48'd180601444137;
    localparam logic [COEF_W-1:0] COEF_B_RST = 48'd64190884978;
    localparam logic [COEF_W-1:0] COEF_C_RST = 48'd16019158;

    typedef struct packed {
        logic vld;
        logic bad;
    } t_ctl;

endpackage

`default_nettype wire

FILE: hdl/ntcf_rdiv.sv
// thermistor resistance from the converter code: product, pipelined divide, series offset when mode is 0
`default_nettype none

module ntcf_rdiv import ntcf_pkg::*; #(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic [ADC_BITS-1:0]       i_code,
    input  logic                      i_mode,
    input  logic [SER_W-1:0]          i_series,
    output t_ctl                      o_ctl,
    output logic [ADC_BITS+SER_W-1:0] o_res
);

    localparam int NUM_W = ADC_BITS + SER_W;
    localparam logic [ADC_BITS-1:0] FULL_SCALE = ADC_BITS'((1 << ADC_BITS) - 2);

    logic [ADC_BITS-1:0] n_mul_a;
    logic [ADC_BITS-1:0] n_den;
    logic                n_bad;

    t_ctl                r_sctl [0:NUM_W];
    logic [ADC_BITS-1:0] r_rem  [0:NUM_W];
    logic [NUM_W-1:0]    r_nq   [0:NUM_W];
    logic [ADC_BITS-1:0] r_den  [0:NUM_W];

    always_comb begin
        n_mul_a = i_mode ? i_code : FULL_SCALE;
        n_den   = i_mode ? ADC_BITS'(FULL_SCALE - i_code) : i_code;
        n_bad   = i_mode ? (i_code >= FULL_SCALE) : (i_code == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sctl[0] <= '0;
        end else begin
            r_sctl[0] <= '{vld: i_vld, bad: n_bad};
        end
    end

    always_ff @(posedge i_clk) begin
        r_nq[0]  <= NUM_W'(n_mul_a) * NUM_W'(i_series);
        r_rem[0] <= '0;
        r_den[0] <= n_den;
    end

    // one quotient bit per stage, msb first
    for (genvar k = 0; k < NUM_W; k++) begin : g_div
        logic [ADC_BITS:0] w_t;
        logic              w_ge;

        assign w_t  = {r_rem[k], r_nq[k][NUM_W-1]};
        assign w_ge = (w_t >= {1'b0, r_den[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sctl[k+1] <= '0;
            end else begin
                r_sctl[k+1] <= r_sctl[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_den[k+1] <= r_den[k];
            r_nq[k+1]  <= {r_nq[k][NUM_W-2:0], w_ge};
            r_rem[k+1] <= w_ge ? ADC_BITS'(w_t - {1'b0, r_den[k]}) : w_t[ADC_BITS-1:0];
        end
    end

    logic [NUM_W-1:0] w_q;
    logic             n_rbad;
    logic [NUM_W-1:0] n_res;

    assign w_q = r_nq[NUM_W];

    always_comb begin
        if (i_mode) begin
            n_rbad = (w_q == '0);
            n_res  = w_q;
        end else begin
            n_rbad = (w_q <= NUM_W'(i_series));
            n_res  = w_q - NUM_W'(i_series);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl <= '{vld: r_sctl[NUM_W].vld, bad: r_sctl[NUM_W].bad | n_rbad};
        end
    end

    always_ff @(posedge i_clk) begin
        o_res <= n_res;
    end

endmodule

`default_nettype wire

FILE: hdl/ntcf_ln.sv
// natural log in Q5.26: leading one, normalize, squaring stages, scale by ln 2
`default_nettype none

module ntcf_ln import ntcf_pkg::*; #(
    parameter int RW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ctl          i_ctl,
    input  logic [RW-1:0] i_r,
    output t_ctl          o_ctl,
    output logic [L_W-1:0] o_l
);

    localparam int E_W = $clog2(RW);
    localparam int X_W = LN_NORM + 1;

    logic [E_W-1:0] n_e;
    t_ctl           r_a_ctl;
    logic [E_W-1:0] r_a_e;
    logic [RW-1:0]  r_a_r;

    always_comb begin
        n_e = '0;
        for (int i = 0; i < RW; i++) begin
            if (i_r[i]) begin
                n_e = E_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else begin
            r_a_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_e <= n_e;
        r_a_r <= i_r;
    end

    // mantissa normalized to Q1.30
    logic [RW+LN_NORM-1:0] w_wide;
    assign w_wide = {r_a_r, LN_NORM'(0)} >> r_a_e;

    t_ctl                r_ctl [0:LOG_FRAC];
    logic [X_W-1:0]      r_x   [0:LOG_FRAC];
    logic [LOG_FRAC-1:0] r_fr  [0:LOG_FRAC];
    logic [E_W-1:0]      r_e   [0:LOG_FRAC];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else begin
            r_ctl[0] <= r_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]  <= w_wide[X_W-1:0];
        r_fr[0] <= '0;
        r_e[0]  <= r_a_e;
    end

    // one fraction bit of log2 per squaring
    for (genvar k = 0; k < LOG_FRAC; k++) begin : g_sq
        logic [2*X_W-1:0] w_sq;
        logic [X_W:0]     w_y;

        assign w_sq = r_x[k] * r_x[k];
        assign w_y  = w_sq[LN_NORM +: X_W+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k+1] <= '0;
            end else begin
                r_ctl[k+1] <= r_ctl[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[k+1]  <= w_y[X_W] ? w_y[X_W:1] : w_y[X_W-1:0];
            r_fr[k+1] <= r_fr[k] | (LOG_FRAC'(w_y[X_W]) << (LOG_FRAC - 1 - k));
            r_e[k+1]  <= r_e[k];
        end
    end

    t_ctl        r_c_ctl;
    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_ctl <= '0;
        end else begin
            r_c_ctl <= r_ctl[LOG_FRAC];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'({r_e[LOG_FRAC], r_fr[LOG_FRAC]}) * 64'(LN2_Q32);
    end

    assign o_ctl = r_c_ctl;
    assign o_l   = r_prod[32 +: L_W];

endmodule

`default_nettype wire

FILE: hdl/ntc_thermistor_to_fahrenheit.sv
// thermistor divider code to whole degrees fahrenheit, steinhart-hart, pipelined
`default_nettype none

// One converter code is taken at every clock edge where start is high; busy
// stays low, so a new code may follow in every cycle. Each result shows on
// o_valid for exactly one cycle, in the order the codes came in; the receiver
// cannot stall the block and must take every result when it appears. The
// pipeline is made of the resistance divider (one quotient bit per stage), the
// 26 squaring stages of the logarithm, the polynomial multiply stages and the
// 10-stage divider of the fahrenheit conversion. Configuration registers are
// written through i_cfg_we / i_cfg_idx / i_cfg_data and must only change while
// no conversion is in flight.
module ntc_thermistor_to_fahrenheit import ntcf_pkg::*; #(
    parameter int ADC_BITS       = ADC_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [ADC_BITS-1:0]  i_adc_code,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data,
    output logic                 o_valid,
    output logic [TEMP_W-1:0]    o_temp_fahrenheit,
    output logic [1:0]           o_status
);

    localparam int RW    = ADC_BITS + SER_W;
    localparam int BL_W  = COEF_W + L_W - LOG_FRAC;
    localparam int CL_W  = COEF_W + L3_W - LOG_FRAC;
    localparam int M_W   = INV_W + 16;
    localparam int DEN_W = INV_W + 7;
    localparam int CMP_W = DEN_W + TEMP_W;
    localparam logic [INV_W-1:0] P_NUM   = 64'd180 << COEF_FRAC_BITS;
    localparam logic [INV_W-1:0] INV_MAX = (P_NUM + 64'd45866) / 64'd45867;
    localparam logic [15:0]      MUL_K   = 16'd45967;
    localparam logic [6:0]       DIV_K   = 7'd100;

    typedef struct packed {
        logic vld;
        logic bad;
        logic below;
        logic zero_t;
        logic sat;
    } t_flags;

    // configuration registers
    logic              r_mode;
    logic [SER_W-1:0]  r_series;
    logic [COEF_W-1:0] r_coef_a;
    logic [COEF_W-1:0] r_coef_b;
    logic [COEF_W-1:0] r_coef_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_series <= SERIES_RST;
            r_coef_a <= COEF_A_RST;
            r_coef_b <= COEF_B_RST;
            r_coef_c <= COEF_C_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:   r_mode   <= i_cfg_data[0];
                CFG_SERIES: r_series <= i_cfg_data[SER_W-1:0];
                CFG_COEF_A: r_coef_a <= i_cfg_data;
                CFG_COEF_B: r_coef_b <= i_cfg_data;
                CFG_COEF_C: r_coef_c <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    t_ctl          w_r_ctl;
    logic [RW-1:0] w_r;
    t_ctl          w_l_ctl;
    logic [L_W-1:0] w_l;

    ntcf_rdiv #(.ADC_BITS(ADC_BITS)) u_rdiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (start & ~busy),
        .i_code   (i_adc_code),
        .i_mode   (r_mode),
        .i_series (r_series),
        .o_ctl    (w_r_ctl),
        .o_res    (w_r)
    );

    ntcf_ln #(.RW(RW)) u_ln (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_r_ctl),
        .i_r     (w_r),
        .o_ctl   (w_l_ctl),
        .o_l     (w_l)
    );

    // polynomial 1/T = A + B*L + C*L^3
    t_ctl r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else begin
            r_c1 <= w_l_ctl;
            r_c2 <= r_c1;
            r_c3 <= r_c2;
            r_c4 <= r_c3;
            r_c5 <= r_c4;
            r_c6 <= r_c5;
        end
    end

    logic [2*L_W-1:0]  r1_l2f;
    logic [L_W+23:0]   r1_bl0;
    logic [L_W+23:0]   r1_bl1;
    logic [L_W-1:0]    r1_l;
    logic [L2_W-1:0]   w_l2;
    logic [L_W+17:0]   r2_p0;
    logic [L_W+17:0]   r2_p1;
    logic [BL_W-1:0]   r2_bl;
    logic [L_W+L2_W-1:0] w_l3f;
    logic [L3_W-1:0]   r3_l3;
    logic [BL_W-1:0]   r3_bl;
    logic [43:0]       r4_q00, r4_q01, r4_q10, r4_q11;
    logic [BL_W-1:0]   r4_bl;
    logic [COEF_W+L3_W-1:0] w_cl3f;
    logic [CL_W-1:0]   r5_cl3;
    logic [INV_W-1:0]  r5_ab;
    logic [INV_W-1:0]  r6_inv;

    assign w_l2   = r1_l2f[LOG_FRAC +: L2_W];
    assign w_l3f  = (L_W+L2_W)'(r2_p0) + ((L_W+L2_W)'(r2_p1) << 18);
    assign w_cl3f = (COEF_W+L3_W)'(r4_q00)
                  + ((COEF_W+L3_W)'(r4_q01) << 20)
                  + ((COEF_W+L3_W)'(r4_q10) << 24)
                  + ((COEF_W+L3_W)'(r4_q11) << 44);

    always_ff @(posedge i_clk) begin
        r1_l2f <= w_l * w_l;
        r1_bl0 <= r_coef_b[23:0] * w_l;
        r1_bl1 <= r_coef_b[47:24] * w_l;
        r1_l   <= w_l;

        r2_p0  <= w_l2[17:0] * r1_l;
        r2_p1  <= w_l2[35:18] * r1_l;
        r2_bl  <= BL_W'(((COEF_W+L_W)'(r1_bl0) + ((COEF_W+L_W)'(r1_bl1) << 24))
                        >> LOG_FRAC);

        r3_l3  <= w_l3f[LOG_FRAC +: L3_W];
        r3_bl  <= r2_bl;

        r4_q00 <= r_coef_c[23:0] * r3_l3[19:0];
        r4_q01 <= r_coef_c[23:0] * r3_l3[39:20];
        r4_q10 <= r_coef_c[47:24] * r3_l3[19:0];
        r4_q11 <= r_coef_c[47:24] * r3_l3[39:20];
        r4_bl  <= r3_bl;

        r5_cl3 <= w_cl3f[LOG_FRAC +: CL_W];
        r5_ab  <= INV_W'(r_coef_a) + INV_W'(r4_bl);

        r6_inv <= r5_ab + INV_W'(r5_cl3);
    end

    // fahrenheit: (p - 45967*inv) / (100*inv)
    t_flags           r7_f, r8_f, r9_f, r10_f;
    logic [47:0]      r7_mlo, r7_mhi;
    logic [DEN_W-1:0] r7_den, r8_den, r9_den, r10_den;
    logic [M_W-1:0]   r8_m;
    logic [INV_W-1:0] r9_num, r10_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_f  <= '0;
            r8_f  <= '0;
            r9_f  <= '0;
            r10_f <= '0;
        end else begin
            r7_f  <= '{vld: r_c6.vld, bad: r_c6.bad | (r6_inv == '0),
                       below: (r6_inv >= INV_MAX), zero_t: 1'b0, sat: 1'b0};
            r8_f  <= r7_f;
            r9_f  <= '{vld: r8_f.vld, bad: r8_f.bad, below: r8_f.below,
                       zero_t: (r8_m >= M_W'(P_NUM)), sat: 1'b0};
            r10_f <= '{vld: r9_f.vld, bad: r9_f.bad, below: r9_f.below,
                       zero_t: r9_f.zero_t,
                       sat: (CMP_W'(r9_num) >= (CMP_W'(r9_den) << TEMP_W))};
        end
    end

    always_ff @(posedge i_clk) begin
        r7_mlo  <= 48'(r6_inv[31:0]) * 48'(MUL_K);
        r7_mhi  <= 48'(r6_inv[63:32]) * 48'(MUL_K);
        r7_den  <= DEN_W'(r6_inv) * DEN_W'(DIV_K);
        r8_m    <= M_W'(r7_mlo) + (M_W'(r7_mhi) << 32);
        r8_den  <= r7_den;
        r9_num  <= P_NUM - r8_m[INV_W-1:0];
        r9_den  <= r8_den;
        r10_num <= r9_num;
        r10_den <= r9_den;
    end

    // restoring divide, one result bit per stage
    t_flags            r_qf  [0:TEMP_W];
    logic [INV_W-1:0]  r_qr  [0:TEMP_W];
    logic [DEN_W-1:0]  r_qd  [0:TEMP_W];
    logic [TEMP_W-1:0] r_qq  [0:TEMP_W];

    assign r_qf[0] = r10_f;
    assign r_qr[0] = r10_num;
    assign r_qd[0] = r10_den;
    assign r_qq[0] = '0;

    for (genvar j = 0; j < TEMP_W; j++) begin : g_fdiv
        logic [CMP_W-1:0] w_d;
        logic             w_ge;

        assign w_d  = CMP_W'(r_qd[j]) << (TEMP_W - 1 - j);
        assign w_ge = (CMP_W'(r_qr[j]) >= w_d);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_qf[j+1] <= '0;
            end else begin
                r_qf[j+1] <= r_qf[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_qr[j+1] <= w_ge ? INV_W'(CMP_W'(r_qr[j]) - w_d) : r_qr[j];
            r_qd[j+1] <= r_qd[j];
            r_qq[j+1] <= r_qq[j] | (TEMP_W'(w_ge) << (TEMP_W - 1 - j));
        end
    end

    t_flags            w_ff;
    logic [TEMP_W-1:0] n_temp;
    logic [1:0]        n_status;

    assign w_ff = r_qf[TEMP_W];

    always_comb begin
        priority if (w_ff.bad) begin
            n_temp   = '0;
            n_status = ST_INVALID;
        end else if (w_ff.below) begin
            n_temp   = '0;
            n_status = ST_SAT;
        end else if (w_ff.zero_t) begin
            n_temp   = '0;
            n_status = ST_OK;
        end else if (w_ff.sat) begin
            n_temp   = '1;
            n_status = ST_SAT;
        end else begin
            n_temp   = r_qq[TEMP_W];
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_ff.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_temp_fahrenheit <= n_temp;
        o_status          <= n_status;
    end

endmodule

`default_nettype wire

FILE: hdl/ntcf_chk.sv
// port-level checks of the thermistor converter, bound to the top level
`default_nettype none

`include "ntc_thermistor_to_fahrenheit_defines.svh"

module ntcf_chk import ntcf_pkg::*; #(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_valid,
    input logic [TEMP_W-1:0]    o_temp_fahrenheit,
    input logic [1:0]           o_status
);

    localparam int LAT = ADC_BITS + LAT_FIXED;

    `NTCF_ASSERT_RST(a_result_follows, i_clk, i_rst_n, (start && !busy) |-> ##LAT o_valid, "transfer accepted but no result after the pipeline latency")
    `NTCF_ASSERT_RST(a_no_spurious, i_clk, i_rst_n, o_valid |-> $past(start && !busy, LAT), "result without a matching transfer")
    `NTCF_ASSERT_RST(a_invalid_zero, i_clk, i_rst_n, (o_valid && o_status == ST_INVALID) |-> (o_temp_fahrenheit == '0), "invalid status with nonzero temperature")
    `NTCF_ASSERT_RST(a_sat_rail, i_clk, i_rst_n, (o_valid && o_status == ST_SAT) |-> (o_temp_fahrenheit == '0 || o_temp_fahrenheit == '1), "saturated status off the rails")
    `NTCF_ASSERT(a_reset_quiet, i_clk, !i_rst_n |=> !o_valid, "result strobe right after reset")

endmodule

bind ntc_thermistor_to_fahrenheit ntcf_chk #(.ADC_BITS(ADC_BITS)) u_ntcf_chk (.*);

`default_nettype wire
